FILE: rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg: shared constants and helpers for the carrot path follower
// Sizes, codes, the saturating coordinate-difference helper and a magnitude helper.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int MAX_WP      = 4096;
  localparam int AW          = $clog2(MAX_WP);
  localparam int SEARCH_BACK = 3;
  localparam int SEARCH_FWD  = 3;
  localparam int COORD_FRAC  = 16;
  localparam int CFG_IW      = 3;

  // Initial search distance: 10000 m in Q16.16.
  localparam logic [31:0] BEST_INIT = 32'(64'd10000 << COORD_FRAC);

  typedef enum logic [CFG_IW-1:0] {
    CFG_LAYER_SIZE = 3'd0,
    CFG_LOOKAHEAD  = 3'd1,
    CFG_START_TH   = 3'd2,
    CFG_MAX_JUMP   = 3'd3,
    CFG_FINISH_RAD = 3'd4
  } cfg_idx_t;

  localparam logic [12:0] RST_LAYER_SIZE = 13'd64;
  localparam logic [30:0] RST_LOOKAHEAD  = 31'd8192;
  localparam logic [30:0] RST_START_TH   = 31'd13107;
  localparam logic [30:0] RST_MAX_JUMP   = 31'd6553600;
  localparam logic [30:0] RST_FINISH_RAD = 31'd11796;

  localparam logic [0:0] OP_LOAD = 1'b0;

  // a - b, clamped to +/-(2^31-1)
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d > 33'sh0_7FFF_FFFF) begin
      sat_diff = 32'sh7FFF_FFFF;
    end else if (d < -33'sh0_7FFF_FFFF) begin
      sat_diff = 32'sh8000_0001;
    end else begin
      sat_diff = d[31:0];
    end
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] d);
    logic [31:0] n;
    n = -d;
    mag31 = d[31] ? n[30:0] : d[30:0];
  endfunction

endpackage

FILE: rtl/carrot_path_follower.sv
// A waypoint load goes straight to the result, a tick on a bad layer to an error
// result. A following tick searches a window of up to 6 waypoints, walks the segments
// and interpolates the carrot. A distance runs 3 squares, a sum and 32 root steps; an
// interpolation runs, on each of 3 axes, a multiply, 64 divide steps and an add.
// Results wait on out_ready. One item at a time; in_ready is high only while idle.
// ----------------------------------------------------------------------------
// carrot_path_follower
// Carrot-chasing path follower over a stored 3D waypoint path, built around
// one multiplier, one restoring square-root step and one restoring divide step
// driven by a one-hot sequencer. Reset (rst_n, synchronous): config to
// defaults, follower state cleared.
// ----------------------------------------------------------------------------
module carrot_path_follower
  import cpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic                  in_restart_layer,
  input  logic [11:0]           in_layer_index,
  input  logic [11:0]           in_wp_index,
  input  logic signed [31:0]    in_pos_x,
  input  logic signed [31:0]    in_pos_y,
  input  logic signed [31:0]    in_pos_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_carrot_x,
  output logic signed [31:0]    out_carrot_y,
  output logic signed [31:0]    out_carrot_z,
  output logic [11:0]           out_nearest_index,
  output logic                  out_layer_done,
  output logic                  out_first_point_reached,
  output logic                  out_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [31:0]           cfg_data
);

  typedef enum logic [29:0] {
    S_IDLE   = 30'b1 << 0,
    S_CHK    = 30'b1 << 1,
    S_CHK2   = 30'b1 << 2,
    S_RD     = 30'b1 << 3,
    S_DSQX   = 30'b1 << 4,
    S_DSQY   = 30'b1 << 5,
    S_DSQZ   = 30'b1 << 6,
    S_DACC   = 30'b1 << 7,
    S_SQRT   = 30'b1 << 8,
    S_P1GOT  = 30'b1 << 9,
    S_P1END  = 30'b1 << 10,
    S_SINIT  = 30'b1 << 11,
    S_SNEXT  = 30'b1 << 12,
    S_SGOT   = 30'b1 << 13,
    S_SCMP   = 30'b1 << 14,
    S_WINIT  = 30'b1 << 15,
    S_WNEXT  = 30'b1 << 16,
    S_WGOTA  = 30'b1 << 17,
    S_WGOTB  = 30'b1 << 18,
    S_WCMP   = 30'b1 << 19,
    S_WLAST  = 30'b1 << 20,
    S_IMUL   = 30'b1 << 21,
    S_IDIV0  = 30'b1 << 22,
    S_IDIV   = 30'b1 << 23,
    S_IADD   = 30'b1 << 24,
    S_JUMP   = 30'b1 << 25,
    S_JCMP   = 30'b1 << 26,
    S_JEND   = 30'b1 << 27,
    S_EGOT   = 30'b1 << 28,
    S_FIN    = 30'b1 << 29
  } state_t;

  // waypoint memories, read data registered
  logic signed [31:0] mem_x [MAX_WP];
  logic signed [31:0] mem_y [MAX_WP];
  logic signed [31:0] mem_z [MAX_WP];
  logic signed [31:0] q_r [3];

  state_t state_r, state_nxt, ret_r, ret_nxt;

  // config
  logic [12:0] lsz_r;
  logic [30:0] look_r, sth_r, mj_r, fin_r;

  // follower state
  logic [AW-1:0]      pclose_r, pclose_nxt, nhold_r, nhold_nxt;
  logic signed [31:0] prevc_r [3], prevc_nxt [3];
  logic               cinit_r, cinit_nxt, reached_r, reached_nxt, near_r, near_nxt;

  // per-item working registers
  logic signed [31:0] pos_r [3], pos_nxt [3];
  logic [11:0]        layer_r, layer_nxt;
  logic [24:0]        base_r, base_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic signed [31:0] da_r [3], da_nxt [3];
  logic signed [31:0] db_r [3], db_nxt [3];
  logic signed [31:0] c_r [3], c_nxt [3];
  logic [63:0]        prod_r, prod_nxt, acc_r, acc_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [12:0]        i_r, i_nxt, hi_r, hi_nxt, j_r, j_nxt;
  logic [31:0]        best_r, best_nxt, rem_r, rem_nxt, seg_r, seg_nxt, dvr_r, dvr_nxt;
  logic [AW-1:0]      closest_r, closest_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [63:0]        num_r, num_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt, done_r, done_nxt, err_r, err_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic signed [31:0] oc_r [3], oc_nxt [3];
  logic [11:0]        onear_r, onear_nxt;
  logic               odone_r, odone_nxt, ofpr_r, ofpr_nxt, oerr_r, oerr_nxt;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic in_fire, cfg_fire;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  logic [31:0]        dist_val; // result of the last distance run
  assign dist_val = res_r[31:0];

  logic [AW-1:0]      last_addr;
  assign last_addr = AW'(base_r[AW-1:0] + lsz_r[AW-1:0] - AW'(1));

  // combinational temporaries
  logic signed [31:0] dtmp;
  logic [63:0]        sq_t;
  logic [32:0]        dv_t;
  logic [13:0]        hi_t;
  logic [31:0]        qv;
  logic [25:0]        end_t;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    pclose_nxt  = pclose_r;
    nhold_nxt   = nhold_r;
    cinit_nxt   = cinit_r;
    reached_nxt = reached_r;
    near_nxt    = near_r;
    layer_nxt   = layer_r;
    base_nxt    = base_r;
    addr_nxt    = addr_r;
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    i_nxt       = i_r;
    hi_nxt      = hi_r;
    j_nxt       = j_r;
    best_nxt    = best_r;
    rem_nxt     = rem_r;
    seg_nxt     = seg_r;
    dvr_nxt     = dvr_r;
    closest_nxt = closest_r;
    ax_nxt      = ax_r;
    num_nxt     = num_r;
    cnt_nxt     = cnt_r;
    neg_nxt     = neg_r;
    done_nxt    = done_r;
    err_nxt     = err_r;
    ov_nxt      = ov_r & ~out_ready;
    onear_nxt   = onear_r;
    odone_nxt   = odone_r;
    ofpr_nxt    = ofpr_r;
    oerr_nxt    = oerr_r;
    for (int k = 0; k < 3; k++) begin
      prevc_nxt[k] = prevc_r[k];
      pos_nxt[k]   = pos_r[k];
      da_nxt[k]    = da_r[k];
      db_nxt[k]    = db_r[k];
      c_nxt[k]     = c_r[k];
      oc_nxt[k]    = oc_r[k];
    end
    mul_a = '0;
    mul_b = '0;
    dtmp  = '0;
    sq_t  = '0;
    dv_t  = '0;
    hi_t  = '0;
    qv    = '0;
    end_t = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_nxt[0] = in_pos_x;
          pos_nxt[1] = in_pos_y;
          pos_nxt[2] = in_pos_z;
          layer_nxt  = in_layer_index;
          for (int k = 0; k < 3; k++) c_nxt[k] = '0;
          done_nxt = 1'b0;
          // every 12-bit address lies inside the memory, so loads never flag
          err_nxt  = 1'b0;
          if (in_op == OP_LOAD) begin
            state_nxt = S_FIN;
          end else begin
            if (in_restart_layer) begin
              reached_nxt = 1'b0;
              near_nxt    = 1'b0;
              cinit_nxt   = 1'b0;
            end
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        // layer base on the shared multiplier
        mul_a     = 32'(layer_r);
        mul_b     = 32'(lsz_r);
        base_nxt  = 25'(mul_p);
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        end_t = 26'(base_r) + 26'(lsz_r);
        if (lsz_r == '0 || end_t > 26'(MAX_WP)) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (!reached_r) begin
          addr_nxt  = base_r[AW-1:0];
          ret_nxt   = S_P1GOT;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_SINIT;
        end
      end
      S_RD: state_nxt = ret_r;

      // ---- distance |da - db|: squares, then 32 root steps ----
      S_DSQX: begin
        dtmp = sat_diff(da_r[0], db_r[0]);
        mul_a = 32'(mag31(dtmp));
        mul_b = 32'(mag31(dtmp));
        prod_nxt  = mul_p;
        state_nxt = S_DSQY;
      end
      S_DSQY: begin
        acc_nxt = prod_r;
        dtmp = sat_diff(da_r[1], db_r[1]);
        mul_a = 32'(mag31(dtmp));
        mul_b = 32'(mag31(dtmp));
        prod_nxt  = mul_p;
        state_nxt = S_DSQZ;
      end
      S_DSQZ: begin
        acc_nxt = acc_r + prod_r;
        dtmp = sat_diff(da_r[2], db_r[2]);
        mul_a = 32'(mag31(dtmp));
        mul_b = 32'(mag31(dtmp));
        prod_nxt  = mul_p;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        acc_nxt   = acc_r + prod_r;
        res_nxt   = '0;
        bit_nxt   = 64'd1 << 62;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        sq_t = res_r + bit_r;
        if (acc_r >= sq_t) begin
          acc_nxt = acc_r - sq_t;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 64'd1) state_nxt = ret_r;
      end

      // ---- phase one: head for the layer start ----
      S_P1GOT: begin
        for (int k = 0; k < 3; k++) begin
          c_nxt[k]  = q_r[k];
          da_nxt[k] = q_r[k];
          db_nxt[k] = pos_r[k];
        end
        ret_nxt   = S_P1END;
        state_nxt = S_DSQX;
      end
      S_P1END: begin
        if (dist_val < {1'b0, sth_r}) reached_nxt = 1'b1;
        if (!cinit_r) begin
          for (int k = 0; k < 3; k++) prevc_nxt[k] = c_r[k];
          cinit_nxt = 1'b1;
        end
        pclose_nxt = '0;
        state_nxt  = S_FIN;
      end

      // ---- phase two: nearest waypoint in the window ----
      S_SINIT: begin
        i_nxt = (pclose_r >= AW'(SEARCH_BACK)) ? 13'(pclose_r - AW'(SEARCH_BACK)) : '0;
        hi_t  = 14'(pclose_r) + 14'(SEARCH_FWD);
        hi_nxt = (hi_t > 14'(lsz_r - 13'd1)) ? (lsz_r - 13'd1) : hi_t[12:0];
        best_nxt    = BEST_INIT;
        closest_nxt = '0;
        state_nxt   = S_SNEXT;
      end
      S_SNEXT: begin
        if (i_r < hi_r) begin
          addr_nxt  = AW'(base_r[AW-1:0] + i_r[AW-1:0]);
          ret_nxt   = S_SGOT;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_WINIT;
        end
      end
      S_SGOT: begin
        for (int k = 0; k < 3; k++) begin
          da_nxt[k] = q_r[k];
          db_nxt[k] = pos_r[k];
        end
        ret_nxt   = S_SCMP;
        state_nxt = S_DSQX;
      end
      S_SCMP: begin
        if (dist_val < best_r) begin
          best_nxt    = dist_val;
          closest_nxt = i_r[AW-1:0];
          nhold_nxt   = AW'(base_r[AW-1:0] + i_r[AW-1:0]);
        end
        i_nxt     = i_r + 13'd1;
        state_nxt = S_SNEXT;
      end

      // ---- walk the lookahead distance along the segments ----
      S_WINIT: begin
        pclose_nxt = closest_r;
        rem_nxt    = {1'b0, look_r};
        j_nxt      = 13'(closest_r);
        state_nxt  = S_WNEXT;
      end
      S_WNEXT: begin
        if (14'(j_r) + 14'd1 < 14'(lsz_r)) begin
          addr_nxt = AW'(base_r[AW-1:0] + j_r[AW-1:0]);
          ret_nxt  = S_WGOTA;
        end else begin
          addr_nxt = last_addr;
          ret_nxt  = S_WLAST;
        end
        state_nxt = S_RD;
      end
      S_WGOTA: begin
        for (int k = 0; k < 3; k++) da_nxt[k] = q_r[k];
        addr_nxt  = AW'(base_r[AW-1:0] + j_r[AW-1:0] + AW'(1));
        ret_nxt   = S_WGOTB;
        state_nxt = S_RD;
      end
      S_WGOTB: begin
        for (int k = 0; k < 3; k++) db_nxt[k] = q_r[k];
        ret_nxt   = S_WCMP;
        state_nxt = S_DSQX;
      end
      S_WCMP: begin
        if (dist_val >= rem_r) begin
          seg_nxt = dist_val;
          if (dist_val == '0) begin
            // zero-length segment: carrot sits on the segment start
            for (int k = 0; k < 3; k++) c_nxt[k] = da_r[k];
            state_nxt = S_JUMP;
          end else begin
            ax_nxt    = '0;
            state_nxt = S_IMUL;
          end
        end else begin
          rem_nxt   = rem_r - dist_val;
          j_nxt     = j_r + 13'd1;
          state_nxt = S_WNEXT;
        end
      end
      S_WLAST: begin
        for (int k = 0; k < 3; k++) c_nxt[k] = q_r[k];
        state_nxt = S_JUMP;
      end

      // ---- interpolation: start + sign(d) * rem*|d|/seg per axis ----
      S_IMUL: begin
        dtmp = sat_diff(db_r[ax_r], da_r[ax_r]);
        mul_a = rem_r;
        mul_b = 32'(mag31(dtmp));
        prod_nxt  = mul_p;
        neg_nxt   = dtmp[31];
        state_nxt = S_IDIV0;
      end
      S_IDIV0: begin
        num_nxt   = prod_r;
        dvr_nxt   = '0;
        cnt_nxt   = 7'd64;
        state_nxt = S_IDIV;
      end
      S_IDIV: begin
        dv_t = {dvr_r, num_r[63]};
        if (dv_t >= {1'b0, seg_r}) begin
          dvr_nxt = 32'(dv_t - {1'b0, seg_r});
          num_nxt = {num_r[62:0], 1'b1};
        end else begin
          dvr_nxt = dv_t[31:0];
          num_nxt = {num_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) state_nxt = S_IADD;
      end
      S_IADD: begin
        qv = num_r[31:0];
        c_nxt[ax_r] = neg_r ? (da_r[ax_r] - $signed(qv)) : (da_r[ax_r] + $signed(qv));
        ax_nxt = ax_r + 2'd1;
        state_nxt = (ax_r == 2'd2) ? S_JUMP : S_IMUL;
      end

      // ---- jump limit, then near-end and completion ----
      S_JUMP: begin
        if (!cinit_r) begin
          cinit_nxt = 1'b1;
          state_nxt = S_JEND;
        end else begin
          for (int k = 0; k < 3; k++) begin
            da_nxt[k] = c_r[k];
            db_nxt[k] = prevc_r[k];
          end
          ret_nxt   = S_JCMP;
          state_nxt = S_DSQX;
        end
      end
      S_JCMP: begin
        if (dist_val > {1'b0, mj_r}) begin
          for (int k = 0; k < 3; k++) c_nxt[k] = prevc_r[k];
        end
        state_nxt = S_JEND;
      end
      S_JEND: begin
        for (int k = 0; k < 3; k++) prevc_nxt[k] = c_r[k];
        if (near_r || (14'(j_r) + 14'd2 >= 14'(lsz_r))) begin
          near_nxt  = 1'b1;
          addr_nxt  = last_addr;
          ret_nxt   = S_EGOT;
          state_nxt = S_RD;
        end else begin
          done_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_EGOT: begin
        for (int k = 0; k < 3; k++) begin
          da_nxt[k] = q_r[k];
          db_nxt[k] = pos_r[k];
        end
        // completion compare is done in S_FIN on the fresh distance
        ret_nxt   = S_FIN;
        done_nxt  = 1'b1;
        state_nxt = S_DSQX;
      end

      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          for (int k = 0; k < 3; k++) oc_nxt[k] = c_r[k];
          onear_nxt = nhold_r;
          odone_nxt = done_r && (dist_val < {1'b0, fin_r});
          ofpr_nxt  = reached_r;
          oerr_nxt  = err_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories: write on a load beat, read every cycle at addr_r
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_LOAD) begin
      mem_x[in_wp_index] <= in_pos_x;
      mem_y[in_wp_index] <= in_pos_y;
      mem_z[in_wp_index] <= in_pos_z;
    end
    q_r[0] <= mem_x[addr_r];
    q_r[1] <= mem_y[addr_r];
    q_r[2] <= mem_z[addr_r];
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      ov_r      <= 1'b0;
      pclose_r  <= '0;
      nhold_r   <= '0;
      cinit_r   <= 1'b0;
      reached_r <= 1'b0;
      near_r    <= 1'b0;
      for (int k = 0; k < 3; k++) prevc_r[k] <= '0;
      lsz_r     <= RST_LAYER_SIZE;
      look_r    <= RST_LOOKAHEAD;
      sth_r     <= RST_START_TH;
      mj_r      <= RST_MAX_JUMP;
      fin_r     <= RST_FINISH_RAD;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      ov_r      <= ov_nxt;
      pclose_r  <= pclose_nxt;
      nhold_r   <= nhold_nxt;
      cinit_r   <= cinit_nxt;
      reached_r <= reached_nxt;
      near_r    <= near_nxt;
      for (int k = 0; k < 3; k++) prevc_r[k] <= prevc_nxt[k];
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_LAYER_SIZE: lsz_r  <= cfg_data[12:0];
          CFG_LOOKAHEAD:  look_r <= cfg_data[30:0];
          CFG_START_TH:   sth_r  <= cfg_data[30:0];
          CFG_MAX_JUMP:   mj_r   <= cfg_data[30:0];
          CFG_FINISH_RAD: fin_r  <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    layer_r   <= layer_nxt;
    base_r    <= base_nxt;
    addr_r    <= addr_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    i_r       <= i_nxt;
    hi_r      <= hi_nxt;
    j_r       <= j_nxt;
    best_r    <= best_nxt;
    rem_r     <= rem_nxt;
    seg_r     <= seg_nxt;
    dvr_r     <= dvr_nxt;
    closest_r <= closest_nxt;
    ax_r      <= ax_nxt;
    num_r     <= num_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    done_r    <= done_nxt;
    err_r     <= err_nxt;
    onear_r   <= onear_nxt;
    odone_r   <= odone_nxt;
    ofpr_r    <= ofpr_nxt;
    oerr_r    <= oerr_nxt;
    for (int k = 0; k < 3; k++) begin
      pos_r[k] <= pos_nxt[k];
      da_r[k]  <= da_nxt[k];
      db_r[k]  <= db_nxt[k];
      c_r[k]   <= c_nxt[k];
      oc_r[k]  <= oc_nxt[k];
    end
  end

  assign out_valid               = ov_r;
  assign out_carrot_x            = oc_r[0];
  assign out_carrot_y            = oc_r[1];
  assign out_carrot_z            = oc_r[2];
  assign out_nearest_index       = onear_r;
  assign out_layer_done          = odone_r;
  assign out_first_point_reached = ofpr_r;
  assign out_error               = oerr_r;

endmodule

FILE: rtl/cpf_checker.sv
// ----------------------------------------------------------------------------
// cpf_checker: port-level checks for carrot_path_follower
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module cpf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_carrot_x,
  input logic signed [31:0] out_carrot_y,
  input logic signed [31:0] out_carrot_z,
  input logic               out_layer_done,
  input logic               out_first_point_reached,
  input logic               out_error
);

  // stalled result beat stays valid and keeps its x carrot
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_carrot_x))
    else $error("result beat dropped or changed while stalled");

  // one item in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |->
      out_carrot_x == 0 && out_carrot_y == 0 && out_carrot_z == 0 && !out_layer_done)
    else $error("error result carries a carrot");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layer_done |-> out_first_point_reached)
    else $error("layer done before start reached");

endmodule

bind carrot_path_follower cpf_checker u_cpf_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_ready                (in_ready),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_carrot_x            (out_carrot_x),
  .out_carrot_y            (out_carrot_y),
  .out_carrot_z            (out_carrot_z),
  .out_layer_done          (out_layer_done),
  .out_first_point_reached (out_first_point_reached),
  .out_error               (out_error)
);
